// File: src/byte_ring_deque_core_assert.svh
// Assertion macros used by the byte ring deque core.
`ifndef BYTE_RING_DEQUE_CORE_ASSERT_SVH
`define BYTE_RING_DEQUE_CORE_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define BRD_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("brd assertion failed");

// When the trigger holds, the condition must hold at the same edge.
`define BRD_ASSERT_IMPL(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("brd assertion failed");

// When the trigger holds, the condition must hold at the next edge.
`define BRD_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("brd assertion failed");

`endif

// File: src/brd_pkg.sv
`timescale 1ns / 1ps

package brd_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int CAP_RESET     = 256;
  localparam int OFF_W         = 8;

  typedef logic [8:0] count_t;
  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK       = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_CHECK_ERR  = 3'd6,
    OP_RESET_ERR  = 3'd7
  } op_t;

endpackage

// File: src/brd_if.sv
`timescale 1ns / 1ps

interface brd_cmd_if;
  logic            valid;
  logic            ready;
  brd_pkg::op_t    op;
  brd_pkg::byte_t  data_in;
  logic [brd_pkg::OFF_W-1:0] peek_offset;

  modport source (output valid, op, data_in, peek_offset, input ready);
  modport sink (input valid, op, data_in, peek_offset, output ready);
endinterface

interface brd_rsp_if;
  logic            valid;
  logic            ready;
  brd_pkg::byte_t  data_out;
  logic            ok;
  brd_pkg::count_t fill_count;
  brd_pkg::count_t free_space;
  logic            error_seen;

  modport source (output valid, data_out, ok, fill_count, free_space, error_seen,
                  input ready);
  modport sink (input valid, data_out, ok, fill_count, free_space, error_seen,
                output ready);
endinterface

interface brd_cfg_if;
  logic            valid;
  logic            ready;
  brd_pkg::count_t capacity;

  modport source (output valid, capacity, input ready);
  modport sink (input valid, capacity, output ready);
endinterface

// File: src/byte_ring_deque_core.sv
`timescale 1ns / 1ps
// Channel   Direction   Payload
// cmd       sink        op, data_in, peek_offset
// rsp       source      data_out, ok, fill_count, free_space, error_seen
// cfg       sink        capacity (write data only)
//
// Push, clear and error ops respond in the cycle after they are taken; pops
// go through a store read (S_READ). Peek runs eight remainder steps for offset
// mod capacity (S_DIV), then an address state (S_ADDR) and a store read (S_READ).
// After reset the store is zeroed one entry per cycle over the first
// min(DEPTH, 512) entries; no command is taken during that pass, configuration writes are.
// A new command is taken once the previous result has left or is leaving.

`include "byte_ring_deque_core_assert.svh"

module byte_ring_deque_core #(
  parameter int DEPTH = brd_pkg::DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  brd_cmd_if.sink         cmd,
  brd_rsp_if.source       rsp,
  brd_cfg_if.sink         cfg
);
  import brd_pkg::*;

  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CLR_N     = (DEPTH < 512) ? DEPTH : 512;
  localparam int CW        = $clog2(OFF_W);
  localparam logic [AW-1:0] CLR_LAST = AW'(CLR_N - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(OFF_W - 1);
  localparam count_t CAP_RST = (CAP_RESET > DEPTH) ? count_t'(DEPTH) : count_t'(CAP_RESET);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DIV   = 5'b00100,
    S_ADDR  = 5'b01000,
    S_READ  = 5'b10000
  } state_t;

  state_t  state, state_next;
  logic [AW-1:0] clr_idx, clr_idx_next;
  count_t  cap_eff, cap_eff_next;
  count_t  head, head_next;
  count_t  fill, fill_next;
  logic    flag, flag_next;
  count_t  rem, rem_next;
  logic [OFF_W-1:0] div_q, div_q_next;
  logic [CW-1:0] div_cnt, div_cnt_next;

  logic    rsp_valid, rsp_valid_next;
  byte_t   rsp_data, rsp_data_next;
  logic    rsp_ok, rsp_ok_next;
  count_t  rsp_fill, rsp_fill_next;
  count_t  rsp_free, rsp_free_next;
  logic    rsp_err, rsp_err_next;

  byte_t   store [DEPTH];
  logic    mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  byte_t   mem_wdata, mem_rdata;

  logic    cmd_fire, cfg_fire;
  logic [9:0] sum_tail, sum_last, sum_peek, rem_shift;
  count_t  pos_tail, pos_last, pos_peek, head_dec, head_inc;
  logic [16:0] cfg_wide;
  count_t  cfg_cap;

  assign cmd.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid;

  assign rsp.valid      = rsp_valid;
  assign rsp.data_out   = rsp_data;
  assign rsp.ok         = rsp_ok;
  assign rsp.fill_count = rsp_fill;
  assign rsp.free_space = rsp_free;
  assign rsp.error_seen = rsp_err;

  // Ring positions: each sum stays below twice the capacity, so one
  // compare and subtract brings it back into range.
  assign sum_tail = {1'b0, head} + {1'b0, fill};
  assign pos_tail = (sum_tail >= {1'b0, cap_eff}) ? count_t'(sum_tail - {1'b0, cap_eff})
                                                  : count_t'(sum_tail);
  assign sum_last = sum_tail - 10'd1;
  assign pos_last = (sum_last >= {1'b0, cap_eff}) ? count_t'(sum_last - {1'b0, cap_eff})
                                                  : count_t'(sum_last);
  assign sum_peek = {1'b0, head} + {1'b0, rem};
  assign pos_peek = (sum_peek >= {1'b0, cap_eff}) ? count_t'(sum_peek - {1'b0, cap_eff})
                                                  : count_t'(sum_peek);
  assign head_dec = (head == '0) ? cap_eff - 9'd1 : head - 9'd1;
  assign head_inc = (head + 9'd1 == cap_eff) ? '0 : head + 9'd1;
  assign rem_shift = {rem, div_q[OFF_W-1]};

  assign cfg_wide = 17'(cfg.capacity);
  assign cfg_cap  = (cfg.capacity == '0) ? 9'd1 :
                    (cfg_wide > 17'(DEPTH)) ? count_t'(DEPTH) : cfg.capacity;

  always_comb begin
    state_next     = state;
    clr_idx_next   = clr_idx;
    cap_eff_next   = cap_eff;
    head_next      = head;
    fill_next      = fill;
    flag_next      = flag;
    rem_next       = rem;
    div_q_next     = div_q;
    div_cnt_next   = div_cnt;
    rsp_valid_next = rsp_valid && !rsp.ready;
    rsp_data_next  = rsp_data;
    rsp_ok_next    = rsp_ok;
    rsp_fill_next  = rsp_fill;
    rsp_free_next  = rsp_free;
    rsp_err_next   = rsp_err;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    unique case (state)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_idx;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == CLR_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_fire) begin
          rsp_ok_next    = 1'b1;
          rsp_data_next  = '0;
          rsp_err_next   = flag;
          rsp_valid_next = 1'b1;
          unique case (cmd.op) inside
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
              if (fill < cap_eff) begin
                mem_we    = 1'b1;
                mem_wdata = cmd.data_in;
                fill_next = fill + 9'd1;
                if (cmd.op == OP_PUSH_BACK) begin
                  mem_waddr = AW'(pos_tail);
                end else begin
                  mem_waddr = AW'(head_dec);
                  head_next = head_dec;
                end
              end else begin
                flag_next    = 1'b1;
                rsp_ok_next  = 1'b0;
                rsp_err_next = 1'b1;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (fill != '0) begin
                mem_re         = 1'b1;
                fill_next      = fill - 9'd1;
                rsp_valid_next = 1'b0;
                state_next     = S_READ;
                if (cmd.op == OP_POP_FRONT) begin
                  mem_raddr = AW'(head);
                  head_next = head_inc;
                end else begin
                  mem_raddr = AW'(pos_last);
                end
              end else begin
                rsp_ok_next = 1'b0;
              end
            end
            OP_PEEK: begin
              rsp_ok_next    = count_t'(cmd.peek_offset) < fill;
              rsp_valid_next = 1'b0;
              rem_next       = '0;
              div_q_next     = cmd.peek_offset;
              div_cnt_next   = '0;
              state_next     = S_DIV;
            end
            OP_CLEAR: begin
              head_next = '0;
              fill_next = '0;
            end
            OP_CHECK_ERR, OP_RESET_ERR: begin
              flag_next = 1'b0;
            end
            default: begin
            end
          endcase
          rsp_fill_next = fill_next;
          rsp_free_next = cap_eff - fill_next;
        end
      end
      S_DIV: begin
        // One restoring step per cycle: remainder of the offset by capacity.
        if (rem_shift >= {1'b0, cap_eff}) begin
          rem_next = count_t'(rem_shift - {1'b0, cap_eff});
        end else begin
          rem_next = count_t'(rem_shift);
        end
        div_q_next   = div_q << 1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        mem_re     = 1'b1;
        mem_raddr  = AW'(pos_peek);
        state_next = S_READ;
      end
      S_READ: begin
        rsp_data_next  = mem_rdata;
        rsp_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase

    if (cfg_fire) begin
      cap_eff_next = cfg_cap;
      head_next    = '0;
      fill_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= store[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      cap_eff   <= CAP_RST;
      head      <= '0;
      fill      <= '0;
      flag      <= 1'b0;
      div_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      cap_eff   <= cap_eff_next;
      head      <= head_next;
      fill      <= fill_next;
      flag      <= flag_next;
      div_cnt   <= div_cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rem      <= rem_next;
    div_q    <= div_q_next;
    rsp_data <= rsp_data_next;
    rsp_ok   <= rsp_ok_next;
    rsp_fill <= rsp_fill_next;
    rsp_free <= rsp_free_next;
    rsp_err  <= rsp_err_next;
  end

  `BRD_ASSERT_ALWAYS(a_fill_in_cap, clk, rst, fill <= cap_eff)
  `BRD_ASSERT_IMPL(a_head_in_cap, clk, rst, fill != '0, head < cap_eff)
  `BRD_ASSERT_IMPL(a_slot_free_on_read, clk, rst, state == S_READ, !rsp_valid)
  `BRD_ASSERT_IMPL(a_counts_sum, clk, rst, rsp_valid,
                   {1'b0, rsp_fill} + {1'b0, rsp_free} == {1'b0, cap_eff})
  `BRD_ASSERT_NEXT(a_pop_reads, clk, rst, cmd_fire && mem_re, state == S_READ)

endmodule
